### src/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

	localparam int unsigned TimeBitsDefault = 32;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_SIZE, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SKIP1,
		PH_SYSLEN, PH_SKIP, PH_MTYPE, PH_MLEN, PH_MDATA, PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CHANNEL = 3'd0,
		KIND_TEMPO   = 3'd1,
		KIND_TIMESIG = 3'd2,
		KIND_EOT     = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	localparam logic [7:0] MetaEot     = 8'h2F;
	localparam logic [7:0] MetaTempo   = 8'h51;
	localparam logic [7:0] MetaTimeSig = 8'h58;
	localparam logic [7:0] StatusMeta  = 8'hFF;

	// Classified event handed from the front part to the back part.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] tstamp;
		logic [7:0]  status;
		logic [31:0] payload;
	} evt_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h54;
			2'd2: r = 8'h72;
			default: r = 8'h6B;
		endcase
		return r;
	endfunction

endpackage

### src/mtep_front.sv
// Front part: byte parser state machine that classifies events.
module mtep_front #(
	parameter int unsigned TIME_BITS = mtep_pkg::TimeBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        data_byte,
	input  logic              track_start,
	input  logic              q_full,
	output logic              ev_push,
	output mtep_pkg::evt_t    ev
);

	mtep_pkg::phase_t phase_q, phase_d, ph;
	logic [2:0]           byte_index_q, byte_index_d, bi;
	logic [27:0]          delta_accum_q, delta_accum_d, da;
	logic [1:0]           delta_bytes_q, delta_bytes_d, db;
	logic [TIME_BITS-1:0] tick_q, tick_d, tk;
	logic [7:0]           running_q, running_d, rs;
	logic [7:0]           current_q, current_d;
	logic [7:0]           held_q, held_d;
	logic [27:0]          skip_q, skip_d, sk;
	logic [7:0]           mtype_q, mtype_d;
	logic [7:0]           mlen_q, mlen_d;
	logic [7:0]           midx_q, midx_d;
	logic [31:0]          mpay_q, mpay_d;
	logic [27:0]          vlq;
	logic [31:0]          tk32;
	logic [7:0]           st;
	logic [7:0]           mi;
	logic [31:0]          mp;
	logic                 fresh;
	logic                 in_take;

	assign in_take = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_MAGIC;
			byte_index_q <= '0;
			delta_accum_q <= '0;
			delta_bytes_q <= '0;
			tick_q <= '0;
			running_q <= '0;
			current_q <= '0;
			held_q <= '0;
			skip_q <= '0;
			mtype_q <= '0;
			mlen_q <= '0;
			midx_q <= '0;
			mpay_q <= '0;
		end else if (in_take) begin
			phase_q <= phase_d;
			byte_index_q <= byte_index_d;
			delta_accum_q <= delta_accum_d;
			delta_bytes_q <= delta_bytes_d;
			tick_q <= tick_d;
			running_q <= running_d;
			current_q <= current_d;
			held_q <= held_d;
			skip_q <= skip_d;
			mtype_q <= mtype_d;
			mlen_q <= mlen_d;
			midx_q <= midx_d;
			mpay_q <= mpay_d;
		end
	end

	always_comb begin
		// A track start clears everything before the byte is examined.
		ph = track_start ? mtep_pkg::PH_MAGIC : phase_q;
		bi = track_start ? 3'd0 : byte_index_q;
		da = track_start ? 28'd0 : delta_accum_q;
		db = track_start ? 2'd0 : delta_bytes_q;
		tk = track_start ? '0 : tick_q;
		rs = track_start ? 8'd0 : running_q;
		sk = track_start ? 28'd0 : skip_q;
		phase_d = ph;
		byte_index_d = bi;
		delta_accum_d = da;
		delta_bytes_d = db;
		tick_d = tk;
		running_d = rs;
		current_d = track_start ? 8'd0 : current_q;
		held_d = track_start ? 8'd0 : held_q;
		skip_d = sk;
		mtype_d = track_start ? 8'd0 : mtype_q;
		mlen_d = track_start ? 8'd0 : mlen_q;
		midx_d = track_start ? 8'd0 : midx_q;
		mpay_d = track_start ? 32'd0 : mpay_q;
		vlq = '0;
		st = '0;
		fresh = 1'b0;
		mi = '0;
		mp = '0;
		ev_push = 1'b0;
		ev.kind = mtep_pkg::KIND_ERROR;
		ev.status = 8'h00;
		ev.payload = '0;
		tk32 = 32'(tk);
		ev.tstamp = tk32;
		unique case (ph)
			mtep_pkg::PH_MAGIC: begin
				if (data_byte != mtep_pkg::magic_byte(bi[1:0])) begin
					ev_push = 1'b1;
					phase_d = mtep_pkg::PH_HALT;
				end else if (bi == 3'd3) begin
					byte_index_d = '0;
					phase_d = mtep_pkg::PH_SIZE;
				end else begin
					byte_index_d = bi + 3'd1;
				end
			end
			mtep_pkg::PH_SIZE: begin
				if (bi == 3'd3) begin
					byte_index_d = '0;
					phase_d = mtep_pkg::PH_DELTA;
				end else begin
					byte_index_d = bi + 3'd1;
				end
			end
			mtep_pkg::PH_DELTA: begin
				vlq = {da[20:0], data_byte[6:0]};
				if (data_byte[7] && db != 2'd3) begin
					delta_accum_d = vlq;
					delta_bytes_d = db + 2'd1;
				end else begin
					tick_d = tk + TIME_BITS'(vlq);
					delta_accum_d = '0;
					delta_bytes_d = '0;
					phase_d = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				fresh = data_byte[7];
				if (fresh) begin
					st = data_byte;
					running_d = (data_byte < 8'hF0) ? data_byte : 8'd0;
				end else begin
					st = rs;
				end
				current_d = st;
				if (!fresh && rs == 8'd0) begin
					ev_push = 1'b1;
					phase_d = mtep_pkg::PH_HALT;
				end else begin
					case (st[7:4])
						4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
							if (fresh) phase_d = mtep_pkg::PH_DATA1;
							else begin
								held_d = data_byte;
								phase_d = mtep_pkg::PH_DATA2;
							end
						end
						4'hC, 4'hD: begin
							phase_d = fresh ? mtep_pkg::PH_SKIP1 : mtep_pkg::PH_DELTA;
						end
						4'hF: begin
							if (st == 8'hF0 || st == 8'hF7) begin
								skip_d = '0;
								delta_bytes_d = '0;
								phase_d = mtep_pkg::PH_SYSLEN;
							end else if (st == mtep_pkg::StatusMeta) begin
								phase_d = mtep_pkg::PH_MTYPE;
							end else begin
								ev_push = 1'b1;
								phase_d = mtep_pkg::PH_HALT;
							end
						end
						default: begin
							ev_push = 1'b1;
							phase_d = mtep_pkg::PH_HALT;
						end
					endcase
				end
			end
			mtep_pkg::PH_DATA1: begin
				held_d = data_byte;
				phase_d = mtep_pkg::PH_DATA2;
			end
			mtep_pkg::PH_DATA2: begin
				ev_push = 1'b1;
				ev.kind = mtep_pkg::KIND_CHANNEL;
				ev.status = current_d;
				ev.payload = {16'd0, held_d, data_byte};
				phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP1: phase_d = mtep_pkg::PH_DELTA;
			mtep_pkg::PH_SYSLEN: begin
				vlq = {sk[20:0], data_byte[6:0]};
				skip_d = vlq;
				if (data_byte[7] && db != 2'd3) begin
					delta_bytes_d = db + 2'd1;
				end else begin
					delta_bytes_d = '0;
					phase_d = (vlq != 28'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SKIP: begin
				vlq = (sk != 28'd0) ? sk - 28'd1 : sk;
				skip_d = vlq;
				if (vlq == 28'd0) phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_MTYPE: begin
				mtype_d = data_byte;
				phase_d = mtep_pkg::PH_MLEN;
			end
			mtep_pkg::PH_MLEN: begin
				mlen_d = data_byte;
				midx_d = '0;
				mpay_d = '0;
				if (mtype_d == mtep_pkg::MetaEot) begin
					ev_push = 1'b1;
					phase_d = mtep_pkg::PH_HALT;
					if (data_byte == 8'd0) begin
						ev.kind = mtep_pkg::KIND_EOT;
						ev.status = mtep_pkg::StatusMeta;
					end
				end else if (mtype_d == mtep_pkg::MetaTempo) begin
					if (data_byte != 8'd3) begin
						ev_push = 1'b1;
						phase_d = mtep_pkg::PH_HALT;
					end else phase_d = mtep_pkg::PH_MDATA;
				end else if (mtype_d == mtep_pkg::MetaTimeSig) begin
					if (data_byte != 8'd4) begin
						ev_push = 1'b1;
						phase_d = mtep_pkg::PH_HALT;
					end else phase_d = mtep_pkg::PH_MDATA;
				end else begin
					skip_d = {20'd0, data_byte};
					phase_d = (data_byte != 8'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_MDATA: begin
				mp = {mpay_d[23:0], data_byte};
				mi = midx_d + 8'd1;
				mpay_d = mp;
				midx_d = mi;
				if (mi >= mlen_d) begin
					phase_d = mtep_pkg::PH_DELTA;
					ev_push = 1'b1;
					ev.status = mtep_pkg::StatusMeta;
					ev.payload = mp;
					ev.kind = (mtype_d == mtep_pkg::MetaTempo) ?
						mtep_pkg::KIND_TEMPO : mtep_pkg::KIND_TIMESIG;
				end
			end
			mtep_pkg::PH_HALT: ;
			default: phase_d = mtep_pkg::PH_HALT;
		endcase
		ev_push = ev_push && in_take;
	end

endmodule

### src/mtep_back.sv
// Back part: event queue and result formatting into output fields.
module mtep_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_push,
	input  mtep_pkg::evt_t    ev,
	output logic              q_full,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        event_kind,
	output logic [31:0]       timestamp,
	output logic [3:0]        command,
	output logic [3:0]        channel,
	output logic [7:0]        first_data,
	output logic [7:0]        second_data,
	output logic [23:0]       tempo_us,
	output logic [7:0]        sig_numerator,
	output logic [7:0]        sig_denominator,
	output logic [7:0]        sig_clocks,
	output logic [7:0]        sig_32nds
);

	localparam int unsigned PtrW = $clog2(mtep_pkg::QueueDepth);

	mtep_pkg::evt_t   mem_q [mtep_pkg::QueueDepth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    cnt_q;
	logic             pop;
	mtep_pkg::evt_t   head;

	assign out_valid = cnt_q != '0;
	assign q_full = cnt_q == (PtrW + 1)'(mtep_pkg::QueueDepth);
	assign pop = out_valid && !out_stall;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (ev_push) mem_q[wr_q] <= ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ev_push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW + 1)'(ev_push) - (PtrW + 1)'(pop);
		end
	end

	always_comb begin
		event_kind = head.kind;
		timestamp = head.tstamp;
		command = head.status[7:4];
		channel = head.status[3:0];
		first_data = '0;
		second_data = '0;
		tempo_us = '0;
		sig_numerator = '0;
		sig_denominator = '0;
		sig_clocks = '0;
		sig_32nds = '0;
		case (head.kind)
			mtep_pkg::KIND_CHANNEL: begin
				first_data = head.payload[15:8];
				second_data = head.payload[7:0];
			end
			mtep_pkg::KIND_TEMPO: tempo_us = head.payload[23:0];
			mtep_pkg::KIND_TIMESIG: begin
				sig_numerator = head.payload[31:24];
				sig_denominator = head.payload[23:16];
				sig_clocks = head.payload[15:8];
				sig_32nds = head.payload[7:0];
			end
			default: ;
		endcase
	end

endmodule

### src/midi_track_event_parser.sv
// Top level of the MIDI track event parser.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | data_byte, track_start
//  output  | out_valid | out_stall | event_kind .. sig_32nds
//
// One byte is taken per cycle unless the queue is full; the parser state
// machine in the front part decides each byte combinationally. Results go
// through a two-entry event queue. Input stalls only when that queue is full,
// so the sender can keep going while the receiver stalls a while.
// Reset is asynchronous and active low and clears all control state.
module midi_track_event_parser #(
	parameter int unsigned TIME_BITS = mtep_pkg::TimeBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [31:0] timestamp,
	output logic [3:0]  command,
	output logic [3:0]  channel,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [23:0] tempo_us,
	output logic [7:0]  sig_numerator,
	output logic [7:0]  sig_denominator,
	output logic [7:0]  sig_clocks,
	output logic [7:0]  sig_32nds
);

	logic           q_full;
	logic           ev_push;
	mtep_pkg::evt_t ev;

	// Stall whenever the queue cannot take another event.
	assign in_stall = q_full;

	mtep_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk, .arst_n, .in_valid, .data_byte, .track_start, .q_full,
		.ev_push, .ev
	);

	mtep_back u_back (
		.clk, .arst_n, .ev_push, .ev, .q_full, .out_valid, .out_stall,
		.event_kind, .timestamp, .command, .channel, .first_data, .second_data,
		.tempo_us, .sig_numerator, .sig_denominator, .sig_clocks, .sig_32nds
	);

endmodule

### tb/midi_track_event_parser_tb.sv
// Self-checking testbench for the MIDI track event parser, driving byte streams and checking events.
module midi_track_event_parser_tb;

	// One byte offered to the parser, with its track-start flag.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} byte_item_t;

	// One parsed event as the parser should report it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] tstamp;
		logic [3:0]  cmd;
		logic [3:0]  chan;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [23:0] tempo;
		logic [7:0]  num;
		logic [7:0]  den;
		logic [7:0]  clks;
		logic [7:0]  n32;
	} midi_event_t;

	localparam int WatchdogLimit = 20000;
	localparam int LongStallCycles = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        track_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [31:0] timestamp;
	logic [3:0]  command;
	logic [3:0]  channel;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [23:0] tempo_us;
	logic [7:0]  sig_numerator;
	logic [7:0]  sig_denominator;
	logic [7:0]  sig_clocks;
	logic [7:0]  sig_32nds;

	midi_track_event_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .track_start(track_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .timestamp(timestamp),
		.command(command), .channel(channel),
		.first_data(first_data), .second_data(second_data),
		.tempo_us(tempo_us), .sig_numerator(sig_numerator),
		.sig_denominator(sig_denominator), .sig_clocks(sig_clocks),
		.sig_32nds(sig_32nds)
	);

	// The stream of bytes still to be offered, filled by the stimulus block.
	byte_item_t  pending_bytes[$];
	// Events predicted from accepted bytes and not yet seen at the output.
	midi_event_t awaited_events[$];

	int  error_count = 0;
	int  bytes_sent = 0;
	int  events_seen = 0;
	int  idle_cycles = 0;
	// Count of accepted bytes at the moment the current offer was made.
	int  offer_mark = 0;
	// Remaining cycles of a sender gap.
	int  gap_left = 0;
	// Set by the stimulus block to make the driver hold off entirely.
	bit  sender_hold = 1'b0;
	// Set by the stimulus block to ask the receiver for one long hold-off.
	bit  long_stall_req = 1'b0;
	// Cycles of the long hold-off already spent, counted by the receiver.
	int  long_stall_count = 0;
	int  stall_run = 0;

	// Private copy of the parser state used for prediction.
	mtep_pkg::phase_t p_phase = mtep_pkg::PH_MAGIC;
	logic [2:0]  p_index = '0;
	logic [27:0] p_delta = '0;
	logic [1:0]  p_delta_n = '0;
	logic [31:0] p_ticks = '0;
	logic [7:0]  p_running = '0;
	logic [7:0]  p_status = '0;
	logic [7:0]  p_held = '0;
	logic [27:0] p_skip = '0;
	logic [7:0]  p_mtype = '0;
	logic [7:0]  p_mlen = '0;
	logic [7:0]  p_midx = '0;
	logic [31:0] p_mpay = '0;

	always #1 clk = ~clk;

	function automatic logic [7:0] track_magic(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h54;
			2'd2: r = 8'h72;
			default: r = 8'h6B;
		endcase
		return r;
	endfunction

	task automatic clear_parser_model();
		p_phase = mtep_pkg::PH_MAGIC;
		p_index = '0;
		p_delta = '0;
		p_delta_n = '0;
		p_ticks = '0;
		p_running = '0;
		p_status = '0;
		p_held = '0;
		p_skip = '0;
		p_mtype = '0;
		p_mlen = '0;
		p_midx = '0;
		p_mpay = '0;
	endtask

	// Queues an event of the given kind, stamped with the current tick count.
	task automatic push_event(input mtep_pkg::kind_t k, input logic [7:0] st,
			input logic [7:0] a, input logic [7:0] b, input logic [23:0] t,
			input logic [31:0] sig);
		midi_event_t e;
		e.kind = k;
		e.tstamp = p_ticks;
		e.cmd = st[7:4];
		e.chan = st[3:0];
		e.d1 = a;
		e.d2 = b;
		e.tempo = t;
		{e.num, e.den, e.clks, e.n32} = sig;
		awaited_events.insert(awaited_events.size(), e);
	endtask

	task automatic raise_error();
		p_phase = mtep_pkg::PH_HALT;
		push_event(mtep_pkg::KIND_ERROR, 8'h00, 8'h00, 8'h00, 24'h0, 32'h0);
	endtask

	// Moves on from a status byte according to the status in effect.
	task automatic route_status(input logic [7:0] b, input bit fresh);
		case (p_status[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
				if (fresh) begin
					p_phase = mtep_pkg::PH_DATA1;
				end else begin
					p_held = b;
					p_phase = mtep_pkg::PH_DATA2;
				end
			end
			4'hC, 4'hD: p_phase = fresh ? mtep_pkg::PH_SKIP1 : mtep_pkg::PH_DELTA;
			4'hF: begin
				if (p_status == 8'hF0 || p_status == 8'hF7) begin
					p_skip = '0;
					p_delta_n = '0;
					p_phase = mtep_pkg::PH_SYSLEN;
				end else if (p_status == mtep_pkg::StatusMeta) begin
					p_phase = mtep_pkg::PH_MTYPE;
				end else begin
					raise_error();
				end
			end
			default: raise_error();
		endcase
	endtask

	// Advances the predictor by one accepted byte.
	task automatic predict_byte(input byte_item_t it);
		logic [7:0] b;
		b = it.data;
		if (it.start)
			clear_parser_model();
		case (p_phase)
			mtep_pkg::PH_MAGIC: begin
				if (b != track_magic(p_index[1:0])) begin
					raise_error();
				end else begin
					p_index = p_index + 3'd1;
					if (p_index >= 3'd4) begin
						p_index = '0;
						p_phase = mtep_pkg::PH_SIZE;
					end
				end
			end
			mtep_pkg::PH_SIZE: begin
				p_index = p_index + 3'd1;
				if (p_index >= 3'd4) begin
					p_index = '0;
					p_phase = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_DELTA: begin
				p_delta = {p_delta[20:0], b[6:0]};
				if (b[7] && p_delta_n < 2'd3) begin
					p_delta_n = p_delta_n + 2'd1;
				end else begin
					p_ticks = p_ticks + 32'(p_delta);
					p_delta = '0;
					p_delta_n = '0;
					p_phase = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (b[7]) begin
					p_status = b;
					p_running = (b < 8'hF0) ? b : 8'h00;
					route_status(b, 1'b1);
				end else if (p_running == 8'h00) begin
					raise_error();
				end else begin
					p_status = p_running;
					route_status(b, 1'b0);
				end
			end
			mtep_pkg::PH_DATA1: begin
				p_held = b;
				p_phase = mtep_pkg::PH_DATA2;
			end
			mtep_pkg::PH_DATA2: begin
				push_event(mtep_pkg::KIND_CHANNEL, p_status, p_held, b, 24'h0, 32'h0);
				p_phase = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP1: p_phase = mtep_pkg::PH_DELTA;
			mtep_pkg::PH_SYSLEN: begin
				p_skip = {p_skip[20:0], b[6:0]};
				if (b[7] && p_delta_n < 2'd3) begin
					p_delta_n = p_delta_n + 2'd1;
				end else begin
					p_delta_n = '0;
					p_phase = (p_skip != 28'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SKIP: begin
				if (p_skip != 28'd0)
					p_skip = p_skip - 28'd1;
				if (p_skip == 28'd0)
					p_phase = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_MTYPE: begin
				p_mtype = b;
				p_phase = mtep_pkg::PH_MLEN;
			end
			mtep_pkg::PH_MLEN: begin
				p_mlen = b;
				p_midx = '0;
				p_mpay = '0;
				if (p_mtype == mtep_pkg::MetaEot) begin
					if (b != 8'd0) begin
						raise_error();
					end else begin
						p_phase = mtep_pkg::PH_HALT;
						push_event(mtep_pkg::KIND_EOT, mtep_pkg::StatusMeta, 8'h00, 8'h00,
							24'h0, 32'h0);
					end
				end else if (p_mtype == mtep_pkg::MetaTempo) begin
					if (b != 8'd3)
						raise_error();
					else
						p_phase = mtep_pkg::PH_MDATA;
				end else if (p_mtype == mtep_pkg::MetaTimeSig) begin
					if (b != 8'd4)
						raise_error();
					else
						p_phase = mtep_pkg::PH_MDATA;
				end else begin
					p_skip = 28'(b);
					p_phase = (b != 8'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_MDATA: begin
				p_mpay = {p_mpay[23:0], b};
				p_midx = p_midx + 8'd1;
				if (p_midx >= p_mlen) begin
					p_phase = mtep_pkg::PH_DELTA;
					if (p_mtype == mtep_pkg::MetaTempo)
						push_event(mtep_pkg::KIND_TEMPO, mtep_pkg::StatusMeta, 8'h00, 8'h00,
							p_mpay[23:0], 32'h0);
					else
						push_event(mtep_pkg::KIND_TIMESIG, mtep_pkg::StatusMeta, 8'h00,
							8'h00, 24'h0, p_mpay);
				end
			end
			default: ;
		endcase
	endtask

	// Helpers that append byte sequences to the pending stream.
	task automatic put_item(input logic [7:0] b, input logic s);
		byte_item_t it;
		it.data = b;
		it.start = s;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic put(input logic [7:0] b);
		put_item(b, 1'b0);
	endtask

	task automatic open_track(input bit with_size_noise);
		put_item(8'h4D, 1'b1);
		put(8'h54);
		put(8'h72);
		put(8'h6B);
		for (int i = 0; i < 4; i++)
			put(with_size_noise ? 8'($urandom) : 8'h00);
	endtask

	// Emits a delta time of 1..4 bytes; the last may carry a set top bit
	// to exercise the over-long delta cut-off.
	task automatic put_delta();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
		for (int i = 0; i < n; i++) begin
			if (i < n - 1)
				put(8'($urandom_range(128, 255)));
			else if (n == 4)
				put(8'($urandom));
			else
				put(8'($urandom_range(0, 127)));
		end
	endtask

	// One well-formed event with random content, including its delta.
	task automatic put_event();
		int pick;
		int len;
		put_delta();
		pick = $urandom_range(0, 11);
		case (pick)
			0, 1, 2, 3: begin
				put(8'($urandom_range(8'h80, 8'hBF)));
				put(8'($urandom));
				put(8'($urandom));
			end
			4: begin
				put(8'($urandom_range(8'hE0, 8'hEF)));
				put(8'($urandom));
				put(8'($urandom));
			end
			5, 6: begin
				// Running status: two data bytes, only works if held.
				put(8'($urandom_range(0, 127)));
				put(8'($urandom));
			end
			7: begin
				put(8'($urandom_range(8'hC0, 8'hDF)));
				put(8'($urandom));
			end
			8: begin
				put(mtep_pkg::StatusMeta);
				put(mtep_pkg::MetaTempo);
				put(8'd3);
				repeat (3) put(8'($urandom));
			end
			9: begin
				put(mtep_pkg::StatusMeta);
				put(mtep_pkg::MetaTimeSig);
				put(8'd4);
				repeat (4) put(8'($urandom));
			end
			10: begin
				put(mtep_pkg::StatusMeta);
				put(8'($urandom_range(0, 8'h0F)));
				len = $urandom_range(0, 5);
				put(8'(len));
				repeat (len) put(8'($urandom));
			end
			default: begin
				put(($urandom_range(0, 1) == 1) ? 8'hF0 : 8'hF7);
				len = $urandom_range(0, 4);
				if ($urandom_range(0, 3) == 0) begin
					put(8'h80);
					put(8'(len));
				end else begin
					put(8'(len));
				end
				repeat (len) put(8'($urandom));
			end
		endcase
	endtask

	// A track made of random events, ending with end of track or with a
	// corrupting byte somewhere.
	task automatic put_track();
		int n_events;
		open_track(1'b1);
		n_events = $urandom_range(2, 8);
		for (int i = 0; i < n_events; i++)
			put_event();
		case ($urandom_range(0, 5))
			0: begin
				put_delta();
				put(8'($urandom_range(8'hF1, 8'hFE)));
			end
			1: begin
				put_delta();
				put(mtep_pkg::StatusMeta);
				put(mtep_pkg::MetaEot);
				put(8'($urandom_range(1, 255)));
			end
			2: repeat ($urandom_range(1, 6)) put(8'($urandom));
			default: begin
				put_delta();
				put(mtep_pkg::StatusMeta);
				put(mtep_pkg::MetaEot);
				put(8'h00);
			end
		endcase
		// Bytes after the end are ignored until the next track start.
		repeat ($urandom_range(0, 2)) put(8'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || awaited_events.size() != 0)
			@(posedge clk);
	endtask

	// Driver: offers the next byte at the falling edge, holding it steady
	// until it has been taken, and inserts random gaps between transfers.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && bytes_sent == offer_mark) begin
				// The transfer is still pending; payload stays put.
			end else if (sender_hold || pending_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if ($urandom_range(0, 99) < 20) begin
				gap_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
					: int'($urandom_range(0, 2));
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				data_byte <= pending_bytes[0].data;
				track_start <= pending_bytes[0].start;
				offer_mark <= bytes_sent;
			end
		end
	end

	// Accepting at the rising edge: the predictor sees each byte once.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_byte(pending_bytes.pop_front());
			bytes_sent <= bytes_sent + 1;
		end
	end

	// Receiver stall: mostly brief, sometimes long, plus a forced long
	// stretch counted here while the sender keeps going.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_stall_req && long_stall_count < LongStallCycles) begin
				long_stall_count <= long_stall_count + 1;
				out_stall <= 1'b1;
			end else if (stall_run > 0) begin
				stall_run <= stall_run - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 15) begin
				stall_run <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
					: int'($urandom_range(0, 3));
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compares each event transfer against the oldest prediction.
	always @(posedge clk) begin
		midi_event_t got;
		midi_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{event_kind, timestamp, command, channel, first_data, second_data,
				tempo_us, sig_numerator, sig_denominator, sig_clocks, sig_32nds};
			events_seen <= events_seen + 1;
			if (awaited_events.size() == 0) begin
				$display("%0t: unexpected event %p", $time, got);
				error_count <= error_count + 1;
			end else begin
				want = awaited_events.pop_front();
				if (got !== want) begin
					$display("%0t: event mismatch, expected %p, actual %p", $time, want, got);
					error_count <= error_count + 1;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("%0t: timeout with %0d bytes queued, %0d events awaited", $time,
					pending_bytes.size(), awaited_events.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: bad magic, data without status, unknown status,
		// extreme channel event and the meta cases.
		put(8'h4D);
		put(8'h00);
		open_track(1'b0);
		put(8'h00);
		put(8'h40);
		open_track(1'b0);
		put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
		put(8'hEF); put(8'hFF); put(8'hFF);
		put(8'h00); put(8'h00); put(8'h00);
		put(8'h00); put(mtep_pkg::StatusMeta); put(mtep_pkg::MetaTempo); put(8'd3);
		put(8'hFF); put(8'hFF); put(8'hFF);
		put(8'h00); put(mtep_pkg::StatusMeta); put(mtep_pkg::MetaTimeSig); put(8'd4);
		put(8'h00); put(8'hFF); put(8'h00); put(8'hFF);
		put(8'h00); put(8'hF5);
		wait_drained();

		// Long receiver hold-off while bytes keep coming, so the event
		// queue fills and the parser stalls its input.
		repeat (4) put_track();
		long_stall_req = 1'b1;
		wait_drained();

		// Sender pause with bytes still queued, until every event is through.
		repeat (3) put_track();
		repeat (40) @(posedge clk);
		sender_hold = 1'b1;
		while (in_valid || awaited_events.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		sender_hold = 1'b0;
		wait_drained();

		while (bytes_sent < 650) begin
			put_track();
			wait_drained();
		end
		repeat (20) @(posedge clk);

		$display("Ran %0d bytes over many tracks and got %0d events,", bytes_sent, events_seen);
		$display("covering channel, tempo, time signature, end of track and error events.");
		if (error_count == 0 && awaited_events.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### filelist.f
src/mtep_pkg.sv
src/mtep_front.sv
src/mtep_back.sv
src/midi_track_event_parser.sv
tb/midi_track_event_parser_tb.sv
